FILE: rtl/core/dqpi_pkg.sv
// Shared types, constants and the microcode table of the dq two-degree-of-freedom PI controller.
// Used by dqpi_seq, dqpi_mac and dq_two_dof_pi_current_ctrl; no dependencies.
package dqpi_pkg;

    localparam int COEF_W    = 32;
    localparam int CUR_W     = 16;
    localparam int ST_W      = 48;
    localparam int PROD_W    = 64;
    localparam int ACC_W     = 66;
    localparam int NUM_COEF  = 8;
    localparam int COEF_IDX_W = 3;
    localparam int CFG_IDX_W = 4;
    localparam int STEP_W    = 5;

    localparam logic [STEP_W-1:0] LAST_STEP = 5'd28;

    localparam logic signed [ST_W-1:0] ST_MAX = {1'b0, {(ST_W-1){1'b1}}};
    localparam logic signed [ST_W-1:0] ST_MIN = {1'b1, {(ST_W-1){1'b0}}};
    localparam logic signed [CUR_W-1:0] PORT_MAX = {1'b0, {(CUR_W-1){1'b1}}};
    localparam logic signed [CUR_W-1:0] PORT_MIN = {1'b1, {(CUR_W-1){1'b0}}};

    // Coefficient register indexes.
    localparam logic [COEF_IDX_W-1:0] CF_FF_A = 3'd0;
    localparam logic [COEF_IDX_W-1:0] CF_FF_B = 3'd1;
    localparam logic [COEF_IDX_W-1:0] CF_FF_C = 3'd2;
    localparam logic [COEF_IDX_W-1:0] CF_FF_D = 3'd3;
    localparam logic [COEF_IDX_W-1:0] CF_FB_A = 3'd4;
    localparam logic [COEF_IDX_W-1:0] CF_FB_B = 3'd5;
    localparam logic [COEF_IDX_W-1:0] CF_FB_C = 3'd6;
    localparam logic [COEF_IDX_W-1:0] CF_FB_D = 3'd7;

    // Operand sources.
    localparam logic [2:0] XS_FF     = 3'd0;
    localparam logic [2:0] XS_DST    = 3'd1;
    localparam logic [2:0] XS_QST    = 3'd2;
    localparam logic [2:0] XS_IQT    = 3'd3;
    localparam logic [2:0] XS_ED     = 3'd4;
    localparam logic [2:0] XS_TMP    = 3'd5;
    localparam logic [2:0] XS_NEGIQM = 3'd6;

    // Accumulator operations.
    localparam logic [2:0] AO_NOP     = 3'd0;
    localparam logic [2:0] AO_LOAD_P  = 3'd1;
    localparam logic [2:0] AO_ADD_P   = 3'd2;
    localparam logic [2:0] AO_ADD_RND = 3'd3;
    localparam logic [2:0] AO_LOAD_X  = 3'd4;
    localparam logic [2:0] AO_ADD_X   = 3'd5;

    // Writeback targets.
    localparam logic [2:0] WB_NONE = 3'd0;
    localparam logic [2:0] WB_TMP  = 3'd1;
    localparam logic [2:0] WB_FF   = 3'd2;
    localparam logic [2:0] WB_DST  = 3'd3;
    localparam logic [2:0] WB_QST  = 3'd4;
    localparam logic [2:0] WB_VD   = 3'd5;
    localparam logic [2:0] WB_VQ   = 3'd6;

    typedef struct packed {
        logic                  mul_en;
        logic                  hi_half;
        logic [COEF_IDX_W-1:0] coef_sel;
        logic [2:0]            x_sel;
        logic [2:0]            acc_op;
        logic [2:0]            wb;
    } uop_t;

    typedef struct packed {
        logic en;
        logic last;
        uop_t uop;
    } ctl_t;

    function automatic uop_t mk_uop(input logic mul_en, input logic hi_half,
                                    input logic [COEF_IDX_W-1:0] coef_sel,
                                    input logic [2:0] x_sel, input logic [2:0] acc_op,
                                    input logic [2:0] wb);
        uop_t u;
        u.mul_en   = mul_en;
        u.hi_half  = hi_half;
        u.coef_sel = coef_sel;
        u.x_sel    = x_sel;
        u.acc_op   = acc_op;
        u.wb       = wb;
        return u;
    endfunction

    // Each product takes a high-half and a low-half multiply; the high product is
    // added as is and the low product rounded.
    function automatic uop_t uop_at(input logic [STEP_W-1:0] step);
        uop_t u;
        unique case (step)
            5'd0:  u = mk_uop(1'b1, 1'b1, CF_FF_C, XS_FF,  AO_NOP,     WB_NONE);
            5'd1:  u = mk_uop(1'b1, 1'b0, CF_FF_C, XS_FF,  AO_LOAD_P,  WB_NONE);
            5'd2:  u = mk_uop(1'b1, 1'b1, CF_FF_D, XS_IQT, AO_ADD_RND, WB_NONE);
            5'd3:  u = mk_uop(1'b1, 1'b0, CF_FF_D, XS_IQT, AO_ADD_P,   WB_NONE);
            5'd4:  u = mk_uop(1'b1, 1'b1, CF_FF_A, XS_FF,  AO_ADD_RND, WB_NONE);
            5'd5:  u = mk_uop(1'b1, 1'b0, CF_FF_A, XS_FF,  AO_LOAD_P,  WB_TMP);
            5'd6:  u = mk_uop(1'b1, 1'b1, CF_FF_B, XS_IQT, AO_ADD_RND, WB_NONE);
            5'd7:  u = mk_uop(1'b1, 1'b0, CF_FF_B, XS_IQT, AO_ADD_P,   WB_NONE);
            5'd8:  u = mk_uop(1'b1, 1'b1, CF_FB_C, XS_DST, AO_ADD_RND, WB_NONE);
            5'd9:  u = mk_uop(1'b1, 1'b0, CF_FB_C, XS_DST, AO_LOAD_P,  WB_FF);
            5'd10: u = mk_uop(1'b1, 1'b1, CF_FB_D, XS_ED,  AO_ADD_RND, WB_NONE);
            5'd11: u = mk_uop(1'b1, 1'b0, CF_FB_D, XS_ED,  AO_ADD_P,   WB_NONE);
            5'd12: u = mk_uop(1'b1, 1'b1, CF_FB_A, XS_DST, AO_ADD_RND, WB_NONE);
            5'd13: u = mk_uop(1'b1, 1'b0, CF_FB_A, XS_DST, AO_LOAD_P,  WB_VD);
            5'd14: u = mk_uop(1'b1, 1'b1, CF_FB_B, XS_ED,  AO_ADD_RND, WB_NONE);
            5'd15: u = mk_uop(1'b1, 1'b0, CF_FB_B, XS_ED,  AO_ADD_P,   WB_NONE);
            5'd16: u = mk_uop(1'b0, 1'b0, CF_FF_A, XS_FF,  AO_ADD_RND, WB_NONE);
            5'd17: u = mk_uop(1'b0, 1'b0, CF_FF_A, XS_TMP, AO_LOAD_X,  WB_DST);
            5'd18: u = mk_uop(1'b0, 1'b0, CF_FF_A, XS_NEGIQM, AO_ADD_X, WB_NONE);
            5'd19: u = mk_uop(1'b1, 1'b1, CF_FB_C, XS_QST, AO_NOP,     WB_TMP);
            5'd20: u = mk_uop(1'b1, 1'b0, CF_FB_C, XS_QST, AO_LOAD_P,  WB_NONE);
            5'd21: u = mk_uop(1'b1, 1'b1, CF_FB_D, XS_TMP, AO_ADD_RND, WB_NONE);
            5'd22: u = mk_uop(1'b1, 1'b0, CF_FB_D, XS_TMP, AO_ADD_P,   WB_NONE);
            5'd23: u = mk_uop(1'b1, 1'b1, CF_FB_A, XS_QST, AO_ADD_RND, WB_NONE);
            5'd24: u = mk_uop(1'b1, 1'b0, CF_FB_A, XS_QST, AO_LOAD_P,  WB_VQ);
            5'd25: u = mk_uop(1'b1, 1'b1, CF_FB_B, XS_TMP, AO_ADD_RND, WB_NONE);
            5'd26: u = mk_uop(1'b1, 1'b0, CF_FB_B, XS_TMP, AO_ADD_P,   WB_NONE);
            5'd27: u = mk_uop(1'b0, 1'b0, CF_FF_A, XS_FF,  AO_ADD_RND, WB_NONE);
            5'd28: u = mk_uop(1'b0, 1'b0, CF_FF_A, XS_FF,  AO_NOP,     WB_QST);
            default: u = mk_uop(1'b0, 1'b0, CF_FF_A, XS_FF, AO_NOP,    WB_NONE);
        endcase
        return u;
    endfunction

endpackage

FILE: rtl/core/dq_two_dof_pi_current_ctrl.sv
// Two-degree-of-freedom dq PI current controller, top level.
// Depends on dqpi_pkg, dqpi_seq and dqpi_mac.
//
// Usage: each input item on the s_ side is one control sample; each produces exactly
// one item on the m_ side with the d and q voltage commands and a saturation flag.
// Coefficients are written through cfg_we / cfg_index / cfg_data while the block is
// idle; indexes 8 and above are ignored.
// Handshake: an item is taken when s_tready is high, which is only while no sample is
// being worked on. The sample then runs through 29 microcode steps on the single
// shared multiplier (twelve products of two halves each, plus writebacks); a new item
// is taken only after the last step of the previous one has run.
// Reset clears all coefficients and the three filter states to zero.
// When the receiver stalls, the finished result is held in the output register and
// the next sample is still accepted; it runs up to its last step and waits there until
// the output register is taken.
module dq_two_dof_pi_current_ctrl
    import dqpi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // q_current_target [15:0], d_current_meas [31:16], q_current_meas [47:32]
    input  logic [47:0]          s_tdata,
    // clear_states [0]
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // d_voltage_cmd [15:0], q_voltage_cmd [31:16]
    output logic [31:0]          m_tdata,
    // saturated [0]
    output logic                 m_tuser
);

    logic signed [COEF_W-1:0] coef_reg [NUM_COEF];
    logic signed [CUR_W-1:0]  iqt_reg;
    logic signed [CUR_W-1:0]  idm_reg;
    logic signed [CUR_W-1:0]  iqm_reg;
    logic signed [ST_W-1:0]   ff_st_reg;
    logic signed [ST_W-1:0]   d_st_reg;
    logic signed [ST_W-1:0]   q_st_reg;
    logic signed [ST_W-1:0]   tmp_reg;
    logic signed [CUR_W-1:0]  vd_reg;
    logic signed [CUR_W-1:0]  vq_reg;
    logic                     sat_reg;
    logic                     m_valid_reg;
    logic [31:0]              m_data_reg;
    logic                     m_user_reg;

    ctl_t                     ctl;
    logic                     in_accept;
    logic                     out_free;
    logic signed [ST_W-1:0]   x_mux;
    logic signed [ACC_W-1:0]  acc;
    logic [CUR_W:0]           neg_idm;
    logic [CUR_W:0]           neg_iqm;
    logic signed [ST_W-1:0]   ed;
    logic signed [ST_W-1:0]   neg_iqm_q;
    logic                     st_ok;
    logic signed [ST_W-1:0]   st_val;
    logic signed [49:0]       port_rnd;
    logic                     port_ok;
    logic signed [CUR_W-1:0]  port_val;
    logic                     wb_state;
    logic                     wb_port;
    logic                     clip_now;

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    dqpi_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .in_ready (s_tready),
        .ctl      (ctl)
    );

    dqpi_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .coef  (coef_reg[ctl.uop.coef_sel]),
        .x     (x_mux),
        .acc   (acc)
    );

    assign neg_idm   = -{idm_reg[CUR_W-1], idm_reg};
    assign neg_iqm   = -{iqm_reg[CUR_W-1], iqm_reg};
    assign ed        = {{(ST_W-CUR_W-17){neg_idm[CUR_W]}}, neg_idm, 16'h0000};
    assign neg_iqm_q = {{(ST_W-CUR_W-17){neg_iqm[CUR_W]}}, neg_iqm, 16'h0000};

    always_comb
    begin
        unique case (ctl.uop.x_sel)
            XS_FF:     x_mux = ff_st_reg;
            XS_DST:    x_mux = d_st_reg;
            XS_QST:    x_mux = q_st_reg;
            XS_IQT:    x_mux = {{(ST_W-CUR_W-16){iqt_reg[CUR_W-1]}}, iqt_reg, 16'h0000};
            XS_ED:     x_mux = ed;
            XS_TMP:    x_mux = tmp_reg;
            XS_NEGIQM: x_mux = neg_iqm_q;
            default:   x_mux = '0;
        endcase
    end

    // Clip of the accumulator to a 48-bit state, and rounding to a 16-bit port value.
    assign st_ok  = (&acc[ACC_W-1:ST_W-1]) || !(|acc[ACC_W-1:ST_W-1]);
    assign st_val = st_ok ? acc[ST_W-1:0] : (acc[ACC_W-1] ? ST_MIN : ST_MAX);

    assign port_rnd = acc[ACC_W-1:16] + {49'd0, acc[15]};
    assign port_ok  = (&port_rnd[49:CUR_W-1]) || !(|port_rnd[49:CUR_W-1]);
    assign port_val = port_ok ? port_rnd[CUR_W-1:0] : (port_rnd[49] ? PORT_MIN : PORT_MAX);

    assign wb_state = (ctl.uop.wb == WB_TMP) || (ctl.uop.wb == WB_FF)
                      || (ctl.uop.wb == WB_DST) || (ctl.uop.wb == WB_QST);
    assign wb_port  = (ctl.uop.wb == WB_VD) || (ctl.uop.wb == WB_VQ);
    assign clip_now = (wb_state && !st_ok) || (wb_port && !port_ok);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEF; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (cfg_we && !cfg_index[CFG_IDX_W-1])
        begin
            coef_reg[cfg_index[COEF_IDX_W-1:0]] <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            iqt_reg <= s_tdata[15:0];
            idm_reg <= s_tdata[31:16];
            iqm_reg <= s_tdata[47:32];
        end
        if (ctl.en)
        begin
            unique case (ctl.uop.wb)
                WB_TMP:  tmp_reg <= st_val;
                WB_VD:   vd_reg  <= port_val;
                WB_VQ:   vq_reg  <= port_val;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ff_st_reg <= '0;
            d_st_reg  <= '0;
            q_st_reg  <= '0;
            sat_reg   <= 1'b0;
        end
        else if (in_accept)
        begin
            sat_reg <= 1'b0;
            if (s_tuser)
            begin
                ff_st_reg <= '0;
                d_st_reg  <= '0;
                q_st_reg  <= '0;
            end
        end
        else if (ctl.en)
        begin
            sat_reg <= sat_reg || clip_now;
            unique case (ctl.uop.wb)
                WB_FF:   ff_st_reg <= st_val;
                WB_DST:  d_st_reg  <= st_val;
                WB_QST:  q_st_reg  <= st_val;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (ctl.en && ctl.last)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en && ctl.last)
        begin
            m_data_reg <= {vq_reg, vd_reg};
            m_user_reg <= sat_reg || clip_now;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

FILE: rtl/core/dqpi_seq.sv
// Sequencer of the dq PI controller: step counter, input handshake and microcode fetch.
// Depends on dqpi_pkg.
module dqpi_seq
    import dqpi_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic out_free,
    output logic in_ready,
    output ctl_t ctl
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic              state_reg;
    logic              state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              is_last;
    logic              run_en;

    assign is_last  = (step_reg == LAST_STEP);
    assign run_en   = (state_reg == ST_RUN) && (!is_last || out_free);
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        ctl.en   = run_en;
        ctl.last = is_last;
        if (state_reg == ST_RUN)
        begin
            ctl.uop = uop_at(step_reg);
        end
        else
        begin
            ctl.uop = mk_uop(1'b0, 1'b0, CF_FF_A, XS_FF, AO_NOP, WB_NONE);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN:
            begin
                if (run_en)
                begin
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

FILE: rtl/core/dqpi_mac.sv
// Shared multiply-accumulate unit: one 32 x 33 signed multiplier and a wide accumulator.
// Depends on dqpi_pkg.
module dqpi_mac
    import dqpi_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  ctl_t                     ctl,
    input  logic signed [COEF_W-1:0] coef,
    input  logic signed [ST_W-1:0]   x,
    output logic signed [ACC_W-1:0]  acc
);

    logic signed [COEF_W:0]        mul_b;
    logic signed [COEF_W+COEF_W:0] prod;
    logic signed [PROD_W-1:0]      p_reg;
    logic signed [PROD_W-1:0]      p_next;
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [ACC_W-1:0]       acc_next;
    logic signed [ACC_W-1:0]       p_ext;
    logic signed [ACC_W-1:0]       rnd_ext;
    logic signed [ACC_W-1:0]       x_ext;

    assign mul_b = ctl.uop.hi_half ? {x[ST_W-1], x[ST_W-1:16]} : {17'd0, x[15:0]};
    assign prod  = coef * mul_b;
    assign p_next = prod[PROD_W-1:0];

    assign p_ext   = {{(ACC_W-PROD_W){p_reg[PROD_W-1]}}, p_reg};
    assign rnd_ext = {{(ACC_W-PROD_W+16){p_reg[PROD_W-1]}}, p_reg[PROD_W-1:16]}
                     + {{(ACC_W-1){1'b0}}, p_reg[15]};
    assign x_ext   = {{(ACC_W-ST_W){x[ST_W-1]}}, x};

    always_comb
    begin
        unique case (ctl.uop.acc_op)
            AO_NOP:     acc_next = acc_reg;
            AO_LOAD_P:  acc_next = p_ext;
            AO_ADD_P:   acc_next = acc_reg + p_ext;
            AO_ADD_RND: acc_next = acc_reg + rnd_ext;
            AO_LOAD_X:  acc_next = x_ext;
            AO_ADD_X:   acc_next = acc_reg + x_ext;
            default:    acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (ctl.en)
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en && ctl.uop.mul_en)
        begin
            p_reg <= p_next;
        end
    end

    assign acc = acc_reg;

endmodule

FILE: test/dq_two_dof_pi_current_ctrl_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the dq two-degree-of-freedom PI current controller.
// Depends on dqpi_pkg and the dq_two_dof_pi_current_ctrl RTL; a fixed-point voltage
// predictor inside checks every command item against directed and random samples.
module dq_two_dof_pi_current_ctrl_test;
    import dqpi_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_SAMPLES = 125;

    typedef struct packed {
        logic        sat;
        logic [15:0] vq;
        logic [15:0] vd;
    } volt_cmd_t;

    class dq_volt_predictor;
        int        gain [NUM_COEF];
        longint    ff_st;
        longint    d_st;
        longint    q_st;
        bit        clip_hit;
        volt_cmd_t volt_expected [$];
        int        mismatches;
        int        clip_results;
        int        checked;

        function new();
            foreach (gain[i])
                gain[i] = 0;
            ff_st = 0;
            d_st = 0;
            q_st = 0;
            mismatches = 0;
            clip_results = 0;
            checked = 0;
        endfunction

        function void set_gain(int idx, int value);
            if (idx < NUM_COEF)
                gain[idx] = value;
        endfunction

        function longint mulq(int a, longint x);
            longint c;
            longint hi;
            longint lo;
            c = a;
            hi = x >>> 16;
            lo = x & 64'hFFFF;
            return c * hi + ((c * lo + 32768) >>> 16);
        endfunction

        function longint sat_add(longint a, longint b);
            longint r;
            r = a + b;
            if (a > 0 && b > 0 && r < 0)
            begin
                clip_hit = 1'b1;
                r = 64'sh7FFF_FFFF_FFFF_FFFF;
            end
            else if (a < 0 && b < 0 && r >= 0)
            begin
                clip_hit = 1'b1;
                r = 64'sh8000_0000_0000_0000;
            end
            return r;
        endfunction

        function longint clip48(longint v);
            longint hi_lim;
            longint lo_lim;
            hi_lim = 64'sh0000_7FFF_FFFF_FFFF;
            lo_lim = -hi_lim - 1;
            if (v > hi_lim)
            begin
                clip_hit = 1'b1;
                return hi_lim;
            end
            if (v < lo_lim)
            begin
                clip_hit = 1'b1;
                return lo_lim;
            end
            return v;
        endfunction

        function logic [15:0] to_port(longint v);
            longint r;
            r = ((v >>> 15) + 1) >>> 1;
            if (r > 32767)
            begin
                clip_hit = 1'b1;
                r = 32767;
            end
            if (r < -32768)
            begin
                clip_hit = 1'b1;
                r = -32768;
            end
            return r[15:0];
        endfunction

        function void take_sample(logic signed [15:0] iqt, logic signed [15:0] idm,
                                  logic signed [15:0] iqm, bit clr);
            longint    t;
            longint    dm;
            longint    qm;
            longint    shaped;
            longint    ed;
            longint    eq;
            longint    vd;
            longint    vq;
            volt_cmd_t cmd;
            t = iqt;
            dm = idm;
            qm = iqm;
            clip_hit = 1'b0;
            if (clr)
            begin
                ff_st = 0;
                d_st = 0;
                q_st = 0;
            end
            shaped = clip48(sat_add(mulq(gain[CF_FF_C], ff_st), longint'(gain[CF_FF_D]) * t));
            ff_st = clip48(sat_add(mulq(gain[CF_FF_A], ff_st), longint'(gain[CF_FF_B]) * t));
            ed = -dm * 65536;
            eq = clip48(shaped - qm * 65536);
            vd = sat_add(mulq(gain[CF_FB_C], d_st), mulq(gain[CF_FB_D], ed));
            d_st = clip48(sat_add(mulq(gain[CF_FB_A], d_st), mulq(gain[CF_FB_B], ed)));
            vq = sat_add(mulq(gain[CF_FB_C], q_st), mulq(gain[CF_FB_D], eq));
            q_st = clip48(sat_add(mulq(gain[CF_FB_A], q_st), mulq(gain[CF_FB_B], eq)));
            cmd.vd = to_port(vd);
            cmd.vq = to_port(vq);
            cmd.sat = clip_hit;
            volt_expected.push_back(cmd);
        endfunction

        task flag_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task match_result(logic [15:0] vd, logic [15:0] vq, logic sat);
            volt_cmd_t want;
            if (volt_expected.size() == 0)
            begin
                flag_mismatch("voltage command item with no sample waiting");
                return;
            end
            want = volt_expected.pop_front();
            checked++;
            if (sat)
                clip_results++;
            if (vd !== want.vd)
                flag_mismatch($sformatf("d_voltage_cmd %0d, want %0d",
                                        $signed(vd), $signed(want.vd)));
            if (vq !== want.vq)
                flag_mismatch($sformatf("q_voltage_cmd %0d, want %0d",
                                        $signed(vq), $signed(want.vq)));
            if (sat !== want.sat)
                flag_mismatch($sformatf("saturated %b, want %b", sat, want.sat));
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COEF_W-1:0]    cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [47:0]          s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [31:0]          m_tdata;
    logic                 m_tuser;

    dq_volt_predictor sb;
    int               cycles = 0;
    int               tx_odds = 4;
    int               rx_odds = 4;
    int               samples = 0;
    int               settings = 0;

    dq_two_dof_pi_current_ctrl u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles with %0d results outstanding.",
                     cycles, sb.volt_expected.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.match_result(m_tdata[15:0], m_tdata[31:16], m_tuser);
    end

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_odds != 0 && $urandom_range(1, rx_odds) == 1)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge clk);
            end
            m_tready = 1'b1;
        end
    end

    task write_gain(int idx, int value);
        cfg_we = 1'b1;
        cfg_index = idx[CFG_IDX_W-1:0];
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.set_gain(idx, value);
    endtask

    task load_gains(int ffa, int ffb, int ffc, int ffd, int fba, int fbb, int fbc, int fbd);
        write_gain(CF_FF_A, ffa);
        write_gain(CF_FF_B, ffb);
        write_gain(CF_FF_C, ffc);
        write_gain(CF_FF_D, ffd);
        write_gain(CF_FB_A, fba);
        write_gain(CF_FB_B, fbb);
        write_gain(CF_FB_C, fbc);
        write_gain(CF_FB_D, fbd);
        settings++;
    endtask

    task send_sample(logic [15:0] iqt, logic [15:0] idm, logic [15:0] iqm, bit clr);
        if (tx_odds != 0 && $urandom_range(1, tx_odds) == 1)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        s_tdata = {iqm, idm, iqt};
        s_tuser = clr;
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sb.take_sample(iqt, idm, iqm, clr);
        samples++;
        @(negedge clk);
    endtask

    // Drains the block so that gains change only while it is idle.
    task settle();
        s_tvalid = 1'b0;
        while (sb.volt_expected.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    function logic [15:0] pick_current();
        case ($urandom_range(0, 5))
            0: return PORT_MAX;
            1: return PORT_MIN;
            2: return 16'($urandom_range(0, 200) - 100);
            default: return 16'($urandom);
        endcase
    endfunction

    task send_edges();
        send_sample(PORT_MAX, PORT_MIN, PORT_MAX, 1'b0);
        send_sample(PORT_MIN, PORT_MAX, PORT_MIN, 1'b0);
        send_sample(16'd100, 16'd100, 16'd100, 1'b0);
        send_sample(16'd0, 16'd0, 16'd0, 1'b1);
    endtask

    initial
    begin
        int g [NUM_COEF];
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Gains are still at their reset value of zero here.
        send_sample(16'd0, 16'd0, 16'd0, 1'b0);
        send_sample(PORT_MAX, PORT_MIN, PORT_MAX, 1'b1);

        settle();
        load_gains(32768, 32768, 65536, 16384, 65536, 8192, 16384, 49152);
        // Out-of-range indexes must leave every gain untouched.
        for (int k = 0; k < NUM_COEF; k++)
            write_gain(NUM_COEF + k, $urandom);
        send_edges();
        send_sample(16'd1, 16'd1, 16'hFFFF, 1'b0);
        send_sample(16'hFFFF, 16'hFFFF, 16'd1, 1'b0);
        send_sample(16'd12345, 16'hFFFD, 16'd3, 1'b0);

        // A lone proportional gain of one half exposes rounding of halves.
        settle();
        load_gains(0, 0, 0, 0, 0, 0, 0, 32768);
        send_sample(16'd0, 16'd1, 16'hFFFF, 1'b0);
        send_sample(16'd0, 16'hFFFF, 16'd1, 1'b0);
        send_sample(16'd0, 16'd3, 16'hFFFD, 1'b0);

        settle();
        load_gains(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                   32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_edges();
        settle();
        load_gains(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                   32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        send_edges();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            settle();
            for (int i = 0; i < NUM_COEF; i++)
            begin
                case ($urandom_range(0, 3))
                    0: g[i] = $urandom;
                    1: g[i] = $urandom_range(0, 262144) - 131072;
                    2: g[i] = $urandom_range(0, 98304) - 16384;
                    default:
                        case ($urandom_range(0, 4))
                            0: g[i] = 32'h7FFFFFFF;
                            1: g[i] = 32'h80000000;
                            2: g[i] = 65536;
                            3: g[i] = -1;
                            default: g[i] = 0;
                        endcase
                endcase
            end
            load_gains(g[0], g[1], g[2], g[3], g[4], g[5], g[6], g[7]);
            if ($urandom_range(0, 1) == 0)
                write_gain($urandom_range(NUM_COEF, 15), $urandom);
            if (ph == RAND_PHASES - 1)
            begin
                tx_odds = 0;
                rx_odds = 0;
            end
            else
            begin
                tx_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
                rx_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
            end
            for (int n = 0; n < PHASE_SAMPLES; n++)
                send_sample(pick_current(), pick_current(), pick_current(),
                            $urandom_range(0, 11) == 0);
        end

        settle();
        $display("Ran %0d control samples under %0d gain settings; %0d results checked.",
                 samples, settings, sb.checked);
        $display("%0d of the results reported clipping.", sb.clip_results);
        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/dqpi_pkg.sv
rtl/core/dqpi_seq.sv
rtl/core/dqpi_mac.sv
rtl/core/dq_two_dof_pi_current_ctrl.sv
test/dq_two_dof_pi_current_ctrl_test.sv
